### hdl/clne_pkg.sv
// ============================================================================
// clne_pkg
// Shared types, constants and tables for the character LCD nibble expander
// sequencer: power-up phases, job descriptors and expander bit layout.
// ============================================================================
package clne_pkg;

    // Power-up sequencer phases
    typedef enum logic [3:0] {
        PH_STARTUP   = 4'd0,
        PH_BACKLIGHT = 4'd1,
        PH_NIB1      = 4'd2,
        PH_NIB2      = 4'd3,
        PH_NIB3      = 4'd4,
        PH_NIB4      = 4'd5,
        PH_FINISH    = 4'd6,
        PH_READY     = 4'd7
    } phase_t;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_CMD    = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_CURSOR = 2'd3
    } mode_t;

    // Work handed from front to back
    typedef enum logic [1:0] {
        JOB_BACKLIGHT = 2'd0,   // one bare write
        JOB_NIBBLE    = 2'd1,   // three writes
        JOB_BYTE      = 2'd2,   // six writes
        JOB_INIT      = 2'd3    // five command bytes, thirty writes
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] value;
        logic       rs;
        logic       ready;
    } job_t;

    // Job queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration register indexes
    localparam logic CFG_IDX_BACKLIGHT = 1'b0;
    localparam logic CFG_IDX_ROWS      = 1'b1;
    localparam logic [2:0] ROWS_RESET  = 3'd2;

    // Millisecond thresholds
    localparam logic [15:0] MS_MAX       = 16'hFFFF;
    localparam logic [15:0] MS_BACKLIGHT = 16'd50;
    localparam logic [15:0] MS_POWER     = 16'd1000;
    localparam logic [15:0] MS_NIB       = 16'd5;
    localparam logic [15:0] MS_NIB_LAST  = 16'd1;

    // Hold times in microseconds
    localparam logic [10:0] WAIT_PLAIN  = 11'd0;
    localparam logic [10:0] WAIT_EN     = 11'd1;
    localparam logic [10:0] WAIT_SETTLE = 11'd50;
    localparam logic [10:0] WAIT_LONG   = 11'd2000;

    // Expander bit layout and fixed nibbles
    localparam logic [7:0] EN_BIT   = 8'h04;
    localparam logic [7:0] NIB_3    = 8'h30;
    localparam logic [7:0] NIB_2    = 8'h20;
    localparam logic [7:0] CURSOR_CMD = 8'h80;

    // Init command list
    localparam logic [2:0] INIT_LAST  = 3'd4;
    localparam logic [2:0] INIT_CLEAR = 3'd2;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = 8'h28;  // function set
            3'd1:    b = 8'h0C;  // display on
            3'd2:    b = 8'h01;  // clear
            3'd3:    b = 8'h06;  // entry mode
            default: b = 8'h02;  // home
        endcase
        return b;
    endfunction

endpackage

### hdl/char_lcd_nibble_expander_sequencer.sv
// ============================================================================
// char_lcd_nibble_expander_sequencer
// Character LCD driver in 4-bit mode through an 8-bit port expander: turns
// ticks, commands, data and cursor items into timed expander writes.
// ============================================================================
//
//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+---------------------
//  input    | s_valid/s_ready, s_mode, s_byte_value,  | valid && ready
//           | s_col, s_row                            |
//  result   | m_valid/m_ready, m_expander_byte,       | valid && ready
//           | m_wait_us, m_last, m_ready_res          |
//  config   | cfg_we, cfg_index, cfg_wdata            | cfg_we high
//
//  Rates: the front takes one item per cycle while the queue has room;
//  the back emits one write per cycle unless the result stalls. A byte
//  item makes six writes, a nibble three, the backlight write one and the
//  final init step thirty; the back sets the sustained rate.
//  Reset: synchronous, active low; clears phase, counter, queue and the
//  output valid flag. No clearing pass is needed.
//  Stalls: a 4-entry job queue decouples the sides; s_ready drops only when
//  it is full, and a stalled result holds in the output register.
//
module char_lcd_nibble_expander_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_byte_value,
    input  logic [5:0]  s_col,
    input  logic [1:0]  s_row,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_wdata,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_expander_byte,
    output logic [10:0] m_wait_us,
    output logic        m_last,
    output logic        m_ready_res
);

    // Front to queue
    logic            q_full;
    logic            q_push;
    clne_pkg::job_t  q_job;
    // Queue to back
    logic            q_empty;
    logic            q_pop;
    clne_pkg::job_t  q_head;
    logic            backlight_on;

    // Classify items, advance the power-up sequencer, hold configuration
    clne_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_byte_value (s_byte_value),
        .s_col        (s_col),
        .s_row        (s_row),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job),
        .backlight_on (backlight_on)
    );

    // Buffer jobs so either side can stall alone
    clne_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head)
    );

    // Expand each job into nibble writes with their hold times
    clne_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .backlight_on    (backlight_on),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_expander_byte (m_expander_byte),
        .m_wait_us       (m_wait_us),
        .m_last          (m_last),
        .m_ready_res     (m_ready_res)
    );

endmodule

### hdl/clne_fifo.sv
// ============================================================================
// clne_fifo
// Short job queue between the classifying front and the write expander.
// ============================================================================
module clne_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  clne_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output clne_pkg::job_t  head_job
);

    clne_pkg::job_t              store_reg [clne_pkg::QDEPTH];
    logic [clne_pkg::QAW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [clne_pkg::QAW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [clne_pkg::QAW:0]      count_reg, count_next;

    assign full     = (count_reg == (clne_pkg::QAW+1)'(clne_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hdl/clne_front.sv
// ============================================================================
// clne_front
// Accepts input items, keeps the millisecond counter, power-up phase and
// configuration, and turns each item into at most one job for the queue.
// ============================================================================
module clne_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_mode,
    input  logic [7:0]      s_byte_value,
    input  logic [5:0]      s_col,
    input  logic [1:0]      s_row,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [2:0]      cfg_wdata,
    input  logic            q_full,
    output logic            q_push,
    output clne_pkg::job_t  q_job,
    output logic            backlight_on
);

    clne_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      ms_reg, ms_next;
    logic             backlight_reg;
    logic [2:0]       rows_reg;

    clne_pkg::mode_t  mode;
    logic             take;
    logic             push;
    logic [15:0]      ms_inc;
    logic             gated;
    logic [15:0]      thr;
    clne_pkg::phase_t ph_after;
    logic [1:0]       row_eff;
    logic [7:0]       cursor_addr;

    assign mode         = clne_pkg::mode_t'(s_mode);
    assign s_ready      = !q_full;
    assign take         = s_valid && s_ready;
    assign q_push       = take && push;
    assign backlight_on = backlight_reg;

    // Clamp the cursor row to the configured display height
    always_comb begin
        row_eff = s_row;
        if ({1'b0, s_row} > rows_reg) begin
            row_eff = (rows_reg == 3'd0) ? 2'd0 : 2'(rows_reg - 3'd1);
        end
        cursor_addr = clne_pkg::CURSOR_CMD
                    | ({2'b00, s_col} + clne_pkg::row_base(row_eff));
    end

    // Per-phase wait threshold and job
    always_comb begin
        gated    = 1'b1;
        thr      = clne_pkg::MS_NIB;
        ph_after = phase_reg;
        case (phase_reg)
            clne_pkg::PH_BACKLIGHT: begin
                thr      = clne_pkg::MS_BACKLIGHT;
                ph_after = clne_pkg::PH_NIB1;
            end
            clne_pkg::PH_NIB1: begin
                thr      = clne_pkg::MS_POWER;
                ph_after = clne_pkg::PH_NIB2;
            end
            clne_pkg::PH_NIB2: begin
                ph_after = clne_pkg::PH_NIB3;
            end
            clne_pkg::PH_NIB3: begin
                ph_after = clne_pkg::PH_NIB4;
            end
            clne_pkg::PH_NIB4: begin
                thr      = clne_pkg::MS_NIB_LAST;
                ph_after = clne_pkg::PH_FINISH;
            end
            default: begin
                gated = 1'b0;
            end
        endcase
    end

    always_comb begin
        ms_inc      = (ms_reg == clne_pkg::MS_MAX) ? ms_reg : ms_reg + 16'd1;
        phase_next  = phase_reg;
        ms_next     = ms_reg;
        push        = 1'b0;
        q_job.kind  = clne_pkg::JOB_BYTE;
        q_job.value = s_byte_value;
        q_job.rs    = 1'b0;
        q_job.ready = 1'b1;
        if (take) begin
            if (mode == clne_pkg::MODE_TICK) begin
                ms_next = ms_inc;
                if (phase_reg == clne_pkg::PH_STARTUP) begin
                    ms_next    = '0;
                    phase_next = clne_pkg::PH_BACKLIGHT;
                end else if (phase_reg == clne_pkg::PH_FINISH) begin
                    push        = 1'b1;
                    q_job.kind  = clne_pkg::JOB_INIT;
                    phase_next  = clne_pkg::PH_READY;
                end else if (gated && ms_inc >= thr) begin
                    ms_next     = '0;
                    push        = 1'b1;
                    phase_next  = ph_after;
                    q_job.ready = 1'b0;
                    if (phase_reg == clne_pkg::PH_BACKLIGHT) begin
                        q_job.kind  = clne_pkg::JOB_BACKLIGHT;
                        q_job.value = '0;
                    end else begin
                        q_job.kind  = clne_pkg::JOB_NIBBLE;
                        q_job.value = (phase_reg == clne_pkg::PH_NIB4) ? clne_pkg::NIB_2
                                                                        : clne_pkg::NIB_3;
                    end
                end
            end else if (phase_reg == clne_pkg::PH_READY) begin
                push = 1'b1;
                if (mode == clne_pkg::MODE_DATA) begin
                    q_job.rs = 1'b1;
                end else if (mode == clne_pkg::MODE_CURSOR) begin
                    q_job.value = cursor_addr;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= clne_pkg::PH_STARTUP;
            ms_reg        <= '0;
            backlight_reg <= 1'b0;
            rows_reg      <= clne_pkg::ROWS_RESET;
        end else begin
            phase_reg <= phase_next;
            ms_reg    <= ms_next;
            if (cfg_we && cfg_index == clne_pkg::CFG_IDX_BACKLIGHT) begin
                backlight_reg <= cfg_wdata[0];
            end
            if (cfg_we && cfg_index == clne_pkg::CFG_IDX_ROWS) begin
                rows_reg <= cfg_wdata;
            end
        end
    end

endmodule

### hdl/clne_back.sv
// ============================================================================
// clne_back
// Expands the job at the head of the queue into expander writes, one per
// cycle while the output is not stalled, into a registered output stage.
// ============================================================================
module clne_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_empty,
    input  clne_pkg::job_t  q_head,
    output logic            q_pop,
    input  logic            backlight_on,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_expander_byte,
    output logic [10:0]     m_wait_us,
    output logic            m_last,
    output logic            m_ready_res
);

    logic [1:0]  sub_reg, sub_next;     // write within a nibble
    logic        half_reg, half_next;   // low nibble of a byte
    logic [2:0]  bidx_reg, bidx_next;   // byte within the init list

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_expander_byte_reg;
    logic [10:0] m_wait_us_reg;
    logic        m_last_reg;
    logic        m_ready_res_reg;

    logic        advance, load, wlast, byte_end, long_now;
    logic [7:0]  src, nib, base, wbyte;
    logic [10:0] wwait;

    always_comb begin
        src      = (q_head.kind == clne_pkg::JOB_INIT) ? clne_pkg::init_byte(bidx_reg)
                                                       : q_head.value;
        nib      = half_reg ? {src[3:0], 4'h0} : {src[7:4], 4'h0};
        base     = nib | {7'b0, q_head.rs} | {4'b0, backlight_on, 3'b0};
        byte_end = (sub_reg == 2'd2) && half_reg;
        long_now = (q_head.kind == clne_pkg::JOB_INIT)
                && (bidx_reg == clne_pkg::INIT_CLEAR || bidx_reg == clne_pkg::INIT_LAST);
        case (sub_reg)
            2'd0: begin
                wbyte = base;
                wwait = clne_pkg::WAIT_PLAIN;
            end
            2'd1: begin
                wbyte = base | clne_pkg::EN_BIT;
                wwait = clne_pkg::WAIT_EN;
            end
            default: begin
                wbyte = base;
                wwait = (long_now && half_reg) ? clne_pkg::WAIT_LONG : clne_pkg::WAIT_SETTLE;
            end
        endcase
        case (q_head.kind)
            clne_pkg::JOB_BACKLIGHT: begin
                wbyte = base;
                wwait = clne_pkg::WAIT_PLAIN;
                wlast = 1'b1;
            end
            clne_pkg::JOB_NIBBLE: wlast = (sub_reg == 2'd2);
            clne_pkg::JOB_BYTE:   wlast = byte_end;
            default:              wlast = byte_end && (bidx_reg == clne_pkg::INIT_LAST);
        endcase
    end

    assign advance = !m_valid_reg || m_ready;
    assign load    = advance && !q_empty;
    assign q_pop   = load && wlast;

    always_comb begin
        sub_next     = sub_reg;
        half_next    = half_reg;
        bidx_next    = bidx_reg;
        m_valid_next = advance ? load : m_valid_reg;
        if (load) begin
            if (wlast) begin
                sub_next  = '0;
                half_next = 1'b0;
                bidx_next = '0;
            end else if (sub_reg == 2'd2) begin
                sub_next = '0;
                if (half_reg) begin
                    half_next = 1'b0;
                    bidx_next = bidx_reg + 3'd1;
                end else begin
                    half_next = 1'b1;
                end
            end else begin
                sub_next = sub_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg     <= '0;
            half_reg    <= 1'b0;
            bidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            sub_reg     <= sub_next;
            half_reg    <= half_next;
            bidx_reg    <= bidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_expander_byte_reg <= wbyte;
            m_wait_us_reg       <= wwait;
            m_last_reg          <= wlast;
            m_ready_res_reg     <= q_head.ready;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_expander_byte = m_expander_byte_reg;
    assign m_wait_us       = m_wait_us_reg;
    assign m_last          = m_last_reg;
    assign m_ready_res     = m_ready_res_reg;

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg != 2'd3)
        else $error("nibble write counter out of range");

    a_bidx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bidx_reg <= clne_pkg::INIT_LAST)
        else $error("init byte index out of range");

    a_en_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_expander_byte_reg[2] |-> m_wait_us_reg == clne_pkg::WAIT_EN)
        else $error("enable-high write without its 1 us hold");

    a_long_en_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_wait_us_reg == clne_pkg::WAIT_LONG |-> !m_expander_byte_reg[2])
        else $error("long hold on a write with enable high");

endmodule

### tb/char_lcd_nibble_expander_sequencer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// char_lcd_nibble_expander_sequencer_test
// Self-checking bench for the LCD nibble expander sequencer. It walks the
// power-up sequence tick by tick, pushes command, data and cursor items
// through under several backlight and row settings, and compares every
// expander write against an in-bench prediction of the writes each item
// causes. Both handshakes see random gaps and stretches without them.
// ============================================================================
module char_lcd_nibble_expander_sequencer_test;
    import clne_pkg::*;

    localparam int    HALF_PERIOD   = 10;
    localparam int    RESET_CYCLES  = 12;
    // Quiet cycles after the last write: covers items still inside the front
    // and queue that cause no write.
    localparam int    SETTLE_CYCLES = 16;
    localparam int    MAX_PRINTED   = 40;
    localparam longint TIMEOUT_NS   = 64'd20_000_000;

    // Power-up command bytes sent by the final init step
    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_CLEAR        = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_HOME         = 8'h02;
    localparam logic       RS_COMMAND       = 1'b0;
    localparam logic       RS_DATA          = 1'b1;

    typedef struct packed {
        logic [7:0]  expander_byte;
        logic [10:0] hold_us;
        logic        last;
        logic        ready_res;
    } lcd_write_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_mode;
    logic [7:0]  s_byte_value;
    logic [5:0]  s_col;
    logic [1:0]  s_row;
    logic        cfg_we;
    logic        cfg_index;
    logic [2:0]  cfg_wdata;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_expander_byte;
    logic [10:0] m_wait_us;
    logic        m_last;
    logic        m_ready_res;

    // Predicted block state and configuration
    phase_t      seq_phase;
    logic [15:0] ms_count;
    logic        bl_on;
    logic [2:0]  rows_cfg;

    lcd_write_t  staged_writes[$];   // writes of the item being predicted
    lcd_write_t  lcd_writes_due[$];  // writes still to come from the block

    int          mismatch_count;
    bit          src_idle_on;
    bit          sink_idle_on;

    char_lcd_nibble_expander_sequencer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_byte_value    (s_byte_value),
        .s_col           (s_col),
        .s_row           (s_row),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_expander_byte (m_expander_byte),
        .m_wait_us       (m_wait_us),
        .m_last          (m_last),
        .m_ready_res     (m_ready_res)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // One expander write; the backlight bit rides along on every write.
    function automatic void stage_write(input logic [7:0] value, input logic [10:0] hold);
        lcd_write_t w;
        w.expander_byte = value | {4'b0000, bl_on, 3'b000};
        w.hold_us       = hold;
        w.last          = 1'b0;
        w.ready_res     = 1'b0;
        staged_writes.push_back(w);
    endfunction

    // A nibble is strobed: plain, enable high, enable low.
    function automatic void stage_nibble(input logic [7:0] value);
        stage_write(value, WAIT_PLAIN);
        stage_write(value | EN_BIT, WAIT_EN);
        stage_write(value & ~EN_BIT, WAIT_SETTLE);
    endfunction

    function automatic void stage_byte(input logic [7:0] value, input logic rs);
        stage_nibble({value[7:4], 3'b000, rs});
        stage_nibble({value[3:0], 3'b000, rs});
    endfunction

    // Clear and home need the long hold on their final strobe.
    function automatic void stage_slow_command(input logic [7:0] value);
        lcd_write_t w;
        stage_byte(value, RS_COMMAND);
        w = staged_writes.pop_back();
        w.hold_us = WAIT_LONG;
        staged_writes.push_back(w);
    endfunction

    function automatic logic [7:0] line_offset(input logic [1:0] line);
        logic [7:0] offset;
        case (line)
            2'd0:    offset = 8'h00;
            2'd1:    offset = 8'h40;
            2'd2:    offset = 8'h14;
            default: offset = 8'h54;
        endcase
        return offset;
    endfunction

    // A tick bumps the saturating counter, then runs one power-up step.
    function automatic void advance_power_up();
        if (ms_count != MS_MAX) ms_count = ms_count + 16'd1;
        case (seq_phase)
            PH_STARTUP: begin
                ms_count  = '0;
                seq_phase = PH_BACKLIGHT;
            end
            PH_BACKLIGHT: if (ms_count >= MS_BACKLIGHT) begin
                ms_count = '0;
                stage_write(8'h00, WAIT_PLAIN);
                seq_phase = PH_NIB1;
            end
            PH_NIB1: if (ms_count >= MS_POWER) begin
                ms_count = '0;
                stage_nibble(NIB_3);
                seq_phase = PH_NIB2;
            end
            PH_NIB2: if (ms_count >= MS_NIB) begin
                ms_count = '0;
                stage_nibble(NIB_3);
                seq_phase = PH_NIB3;
            end
            PH_NIB3: if (ms_count >= MS_NIB) begin
                ms_count = '0;
                stage_nibble(NIB_3);
                seq_phase = PH_NIB4;
            end
            PH_NIB4: if (ms_count >= MS_NIB_LAST) begin
                ms_count = '0;
                stage_nibble(NIB_2);
                seq_phase = PH_FINISH;
            end
            PH_FINISH: begin
                stage_byte(LCD_FUNCTION_SET, RS_COMMAND);
                stage_byte(LCD_DISPLAY_ON, RS_COMMAND);
                stage_slow_command(LCD_CLEAR);
                stage_byte(LCD_ENTRY_MODE, RS_COMMAND);
                stage_slow_command(LCD_HOME);
                seq_phase = PH_READY;
            end
            default: ;
        endcase
    endfunction

    // Work out every write an accepted item causes and queue them.
    function automatic void predict_lcd_writes(input mode_t mode, input logic [7:0] value,
                                               input logic [5:0] col, input logic [1:0] row);
        logic [1:0] line;
        logic [2:0] top_line;
        lcd_write_t w;
        staged_writes.delete();
        line = row;
        if (mode == MODE_TICK) begin
            advance_power_up();
        end else if (seq_phase == PH_READY) begin
            case (mode)
                MODE_CMD:  stage_byte(value, RS_COMMAND);
                MODE_DATA: stage_byte(value, RS_DATA);
                default: begin
                    // Clamp rows past the configured count to the bottom line.
                    if ({1'b0, row} > rows_cfg) begin
                        top_line = rows_cfg - 3'd1;
                        line = (rows_cfg == 3'd0) ? 2'd0 : top_line[1:0];
                    end
                    stage_byte(CURSOR_CMD | ({2'b00, col} + line_offset(line)), RS_COMMAND);
                end
            endcase
        end
        for (int i = 0; i < staged_writes.size(); i++) begin
            w = staged_writes[i];
            w.last      = (i == staged_writes.size() - 1);
            w.ready_res = (seq_phase == PH_READY);
            lcd_writes_due.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Compare each write transfer against the oldest outstanding prediction.
    always @(posedge aclk) begin
        lcd_write_t due;
        if (aresetn && m_valid && m_ready) begin
            if (lcd_writes_due.size() == 0) begin
                report_mismatch("write with nothing pending", m_expander_byte, 0);
            end else begin
                due = lcd_writes_due.pop_front();
                if (m_expander_byte !== due.expander_byte)
                    report_mismatch("expander_byte", m_expander_byte, due.expander_byte);
                if (m_wait_us !== due.hold_us)
                    report_mismatch("wait_us", m_wait_us, due.hold_us);
                if (m_last !== due.last)
                    report_mismatch("last", m_last, due.last);
                if (m_ready_res !== due.ready_res)
                    report_mismatch("ready_res", m_ready_res, due.ready_res);
            end
        end
    end

    // Write side: draw a stall before every transfer when stalls are on.
    initial begin
        int stall;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = sink_idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one item and hold it until the transfer; valid stays high on
    // return so back-to-back items need no dip.
    task automatic send_item(input mode_t mode, input logic [7:0] value,
                             input logic [5:0] col, input logic [1:0] row);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_byte_value <= value;
        s_col        <= col;
        s_row        <= row;
        do @(posedge aclk); while (!s_ready);
        predict_lcd_writes(mode, value, col, row);
    endtask

    task automatic send_random_payload(input mode_t mode);
        send_item(mode, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)));
    endtask

    // Drop valid and wait until the block has nothing left in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (lcd_writes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic index, input logic [2:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        if (index == CFG_IDX_BACKLIGHT) bl_on = value[0];
        else rows_cfg = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic backlight, input logic [2:0] rows);
        wait_idle();
        write_register(CFG_IDX_BACKLIGHT, {2'b00, backlight});
        write_register(CFG_IDX_ROWS, rows);
    endtask

    // Ticks until the predicted phase is reached; one item in five is a
    // command, data or cursor item that must be dropped while not ready.
    task automatic tick_until(input phase_t target);
        while (seq_phase != target) begin
            if ($urandom_range(0, 4) == 0)
                send_random_payload(mode_t'($urandom_range(1, 3)));
            else
                send_random_payload(MODE_TICK);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Nothing may come out for command, data or cursor items before power-up.
    task automatic test_dropped_before_ready();
        send_item(MODE_CMD, 8'hFF, 6'd0, 2'd0);
        send_item(MODE_DATA, 8'h00, 6'd63, 2'd3);
        send_item(MODE_CURSOR, 8'hA5, 6'd63, 2'd3);
        send_item(MODE_CURSOR, 8'h5A, 6'd0, 2'd0);
    endtask

    // Full power-up: startup, backlight write, three 3-nibbles, the 2-nibble
    // and the thirty-write command burst. Turn the backlight on midway.
    task automatic test_power_up();
        tick_until(PH_NIB1);
        apply_settings(1'b1, ROWS_RESET);
        tick_until(PH_READY);
        // Ticks after ready cause nothing.
        send_random_payload(MODE_TICK);
        send_random_payload(MODE_TICK);
    endtask

    task automatic test_bytes_after_ready();
        apply_settings(1'b0, ROWS_RESET);
        send_item(MODE_CMD, 8'h00, 6'd0, 2'd0);
        send_item(MODE_CMD, 8'hFF, 6'd63, 2'd3);
        send_item(MODE_DATA, 8'hFF, 6'd0, 2'd0);
        send_item(MODE_DATA, 8'h00, 6'd63, 2'd3);
        send_item(MODE_DATA, 8'hA5, 6'd21, 2'd1);
        send_item(MODE_CMD, 8'h5A, 6'd42, 2'd2);
        send_item(MODE_TICK, 8'hFF, 6'd63, 2'd3);
    endtask

    // Cursor addressing: every row under a few row counts, zero rows included.
    task automatic test_cursor_rows();
        logic [2:0] row_counts[3] = '{3'd4, 3'd1, 3'd0};
        foreach (row_counts[k]) begin
            apply_settings(k[0], row_counts[k]);
            send_item(MODE_CURSOR, 8'h00, 6'd0, 2'd0);
            send_item(MODE_CURSOR, 8'hFF, 6'd63, 2'd1);
            send_item(MODE_CURSOR, 8'h00, 6'd39, 2'd2);
            send_item(MODE_CURSOR, 8'hFF, 6'($urandom_range(0, 63)), 2'd3);
        end
    endtask

    // Mixed traffic in four settings, each with its own idling pattern.
    task automatic test_random_traffic();
        logic [2:0] row_counts[4] = '{3'd3, 3'd7, 3'd1, 3'd4};
        int pick;
        for (int p = 0; p < 4; p++) begin
            apply_settings(p[0], row_counts[p]);
            src_idle_on  = (p == 0) || (p == 2);
            sink_idle_on = (p == 0) || (p == 3);
            repeat (92) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)      send_random_payload(MODE_TICK);
                else if (pick < 5) send_random_payload(MODE_CMD);
                else if (pick < 8) send_random_payload(MODE_DATA);
                else               send_random_payload(MODE_CURSOR);
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        seq_phase      = PH_STARTUP;
        ms_count       = '0;
        bl_on          = 1'b0;
        rows_cfg       = ROWS_RESET;
        mismatch_count = 0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_mode       <= MODE_TICK;
        s_byte_value <= '0;
        s_col        <= '0;
        s_row        <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_IDX_BACKLIGHT;
        cfg_wdata    <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_dropped_before_ready();
        test_power_up();
        test_bytes_after_ready();
        test_cursor_rows();
        test_random_traffic();

        // Drain, then give stray writes a chance to show up.
        wait_idle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #TIMEOUT_NS;
        $display("simulation failed");
        $finish;
    end

endmodule
